// ===== rtl/cbt_pkg.sv =====
// Shared types and constants for the cubic Bezier tessellator.
package cbt_pkg;

    localparam int COORD_W              = 24;
    localparam int INDEX_W              = 6;
    localparam int CURVE_POINTS         = 4;
    localparam int SAMPLE_COUNT_DEFAULT = 64;
    localparam int WEIGHT_FRAC_DEFAULT  = 16;

    localparam logic [COORD_W-1:0] COORD_MAX = 24'h7F_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 24'h80_0000;

    typedef logic [CURVE_POINTS-1:0][COORD_W-1:0] coord_vec_t;

    // One curve: element 0 is the start point, 3 the end point.
    typedef struct packed {
        coord_vec_t x;
        coord_vec_t y;
    } curve_t;

    // Bookkeeping that follows a sample down the pipeline.
    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] index;
        logic               last;
    } sample_tag_t;

endpackage

// ===== rtl/cbt_queue.sv =====
// Two-entry curve queue between the request side and the sample engine.
module cbt_queue
    import cbt_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  curve_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output curve_t head_data
);

    curve_t     mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = mem_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/cbt_blend.sv =====
// Pipelined weighted sum of four control coordinates with rounding and saturation.
module cbt_blend
    import cbt_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEFAULT
)
(
    input  logic                                       aclk,
    input  logic                                       en,
    input  logic [CURVE_POINTS-1:0][WEIGHT_FRAC_BITS:0] weight,
    input  coord_vec_t                                 coord,
    output logic [COORD_W-1:0]                         result
);

    localparam int PROD_W = WEIGHT_FRAC_BITS + 2 + COORD_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SH_W   = SUM_W - WEIGHT_FRAC_BITS;

    localparam logic signed [SUM_W-1:0] ROUND_HALF =
        {{(SUM_W - WEIGHT_FRAC_BITS){1'b0}}, 1'b1, {(WEIGHT_FRAC_BITS-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg [CURVE_POINTS];
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [SH_W-1:0]   shifted;
    logic [SH_W-COORD_W:0]    top_bits;

    // Stage one: one multiplier per control point.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < CURVE_POINTS; k++) begin
                prod_reg[k] <= $signed({1'b0, weight[k]}) * $signed(coord[k]);
            end
        end
    end

    // Stage two: sum of the products plus half an output LSB.
    assign sum_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
                    + SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]) + ROUND_HALF;

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
        end
    end

    // Dropping the fraction after the bias gives round to nearest, halves up.
    assign shifted  = SH_W'(sum_reg >>> WEIGHT_FRAC_BITS);
    assign top_bits = shifted[SH_W-1:COORD_W-1];

    always_comb begin
        if ((&top_bits) || !(|top_bits)) begin
            result = shifted[COORD_W-1:0];
        end else if (shifted[SH_W-1]) begin
            result = COORD_MIN;
        end else begin
            result = COORD_MAX;
        end
    end

endmodule

// ===== rtl/cbt_engine.sv =====
// Sample sequencer, Bernstein weight table and output register of the tessellator.
module cbt_engine
    import cbt_pkg::*;
#(
    parameter int SAMPLE_COUNT     = SAMPLE_COUNT_DEFAULT,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEFAULT
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               head_valid,
    input  curve_t             head_data,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COORD_W-1:0] m_sample_x,
    output logic [COORD_W-1:0] m_sample_y,
    output logic [INDEX_W-1:0] m_sample_index,
    output logic               m_last
);

    localparam int CNT_W = $clog2(SAMPLE_COUNT);
    localparam int WW    = WEIGHT_FRAC_BITS + 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLE_COUNT - 1);
    localparam longint unsigned D  = longint'(SAMPLE_COUNT - 1);
    localparam longint unsigned D3 = D * D * D;

    typedef logic [CURVE_POINTS-1:0][WW-1:0] weight_set_t;

    weight_set_t wtab [SAMPLE_COUNT];

    // Weight k of sample i is round(num_k * 2^F / d^3), num being the Bernstein numerator.
    for (genvar gi = 0; gi < SAMPLE_COUNT; gi++) begin : g_wtab
        localparam longint unsigned SI = longint'(gi);
        localparam longint unsigned SU = D - SI;
        localparam longint unsigned W0 =
            (((SU * SU * SU) << WEIGHT_FRAC_BITS) + D3 / 2) / D3;
        localparam longint unsigned W1 =
            (((3 * SI * SU * SU) << WEIGHT_FRAC_BITS) + D3 / 2) / D3;
        localparam longint unsigned W2 =
            (((3 * SI * SI * SU) << WEIGHT_FRAC_BITS) + D3 / 2) / D3;
        localparam longint unsigned W3 =
            (((SI * SI * SI) << WEIGHT_FRAC_BITS) + D3 / 2) / D3;
        assign wtab[gi] = {WW'(W3), WW'(W2), WW'(W1), WW'(W0)};
    end

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               adv, issue;
    sample_tag_t        s1_tag_reg, s2_tag_reg, s3_tag_reg;
    sample_tag_t        s1_tag_next;
    weight_set_t        s1_w_reg;
    curve_t             s1_pt_reg;
    logic               m_valid_reg;
    logic [COORD_W-1:0] m_x_reg, m_y_reg;
    logic [INDEX_W-1:0] m_index_reg;
    logic               m_last_reg;
    logic [COORD_W-1:0] blend_x, blend_y;

    // The whole pipeline moves as one whenever the output register can take a sample.
    assign adv   = !m_valid_reg || m_ready;
    assign issue = adv && head_valid;
    assign pop   = issue && (cnt_reg == LAST_CNT);

    always_comb begin
        cnt_next = cnt_reg;
        if (issue) begin
            cnt_next = (cnt_reg == LAST_CNT) ? '0 : cnt_reg + 1'b1;
        end
        s1_tag_next.valid = head_valid;
        s1_tag_next.index = INDEX_W'(cnt_reg);
        s1_tag_next.last  = (cnt_reg == LAST_CNT);
    end

    // Only the valid bits of the tags need a reset value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg           <= '0;
            s1_tag_reg.valid  <= 1'b0;
            s2_tag_reg.valid  <= 1'b0;
            s3_tag_reg.valid  <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (adv) begin
                s1_tag_reg  <= s1_tag_next;
                s2_tag_reg  <= s1_tag_reg;
                s3_tag_reg  <= s2_tag_reg;
                m_valid_reg <= s3_tag_reg.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_w_reg         <= wtab[cnt_reg];
            s1_pt_reg        <= head_data;
            m_x_reg          <= blend_x;
            m_y_reg          <= blend_y;
            m_index_reg      <= s3_tag_reg.index;
            m_last_reg       <= s3_tag_reg.last;
        end
    end

    cbt_blend #(
        .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
    ) u_blend_x (
        .aclk  (aclk),
        .en    (adv),
        .weight(s1_w_reg),
        .coord (s1_pt_reg.x),
        .result(blend_x)
    );

    cbt_blend #(
        .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
    ) u_blend_y (
        .aclk  (aclk),
        .en    (adv),
        .weight(s1_w_reg),
        .coord (s1_pt_reg.y),
        .result(blend_y)
    );

    assign m_valid        = m_valid_reg;
    assign m_sample_x     = m_x_reg;
    assign m_sample_y     = m_y_reg;
    assign m_sample_index = m_index_reg;
    assign m_last         = m_last_reg;

endmodule

// ===== rtl/cubic_bezier_tessellator.sv =====
// Top level of the cubic Bezier tessellator: curve queue, sample engine and checks.
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_valid / s_ready   four control points, signed Q16.8
//   m_        out        m_valid / m_ready   sample x/y (Q16.8), index, last flag
//
// Each curve request yields SAMPLE_COUNT samples, one per cycle while m_ready is high.
// The x and y coordinates run through two separate blend pipelines fed by one weight
// table. A head curve's samples pass the weight/point, product, sum and output registers.
// Reset (synchronous, active low) empties the queue and clears every pipeline valid.
// A stalled output freezes the whole sample pipeline in place; the two-entry queue in
// front keeps taking requests until it is full, so the input side stalls on its own.
module cubic_bezier_tessellator
    import cbt_pkg::*;
#(
    parameter int SAMPLE_COUNT     = SAMPLE_COUNT_DEFAULT,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEFAULT
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COORD_W-1:0] s_start_x,
    input  logic [COORD_W-1:0] s_start_y,
    input  logic [COORD_W-1:0] s_ctrl1_x,
    input  logic [COORD_W-1:0] s_ctrl1_y,
    input  logic [COORD_W-1:0] s_ctrl2_x,
    input  logic [COORD_W-1:0] s_ctrl2_y,
    input  logic [COORD_W-1:0] s_end_x,
    input  logic [COORD_W-1:0] s_end_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COORD_W-1:0] m_sample_x,
    output logic [COORD_W-1:0] m_sample_y,
    output logic [INDEX_W-1:0] m_sample_index,
    output logic               m_last
);

    curve_t in_curve;
    curve_t head_data;
    logic   q_full;
    logic   head_valid;
    logic   q_pop;

    // Pack the request into one curve word, start point in element zero.
    assign in_curve.x = {s_end_x, s_ctrl2_x, s_ctrl1_x, s_start_x};
    assign in_curve.y = {s_end_y, s_ctrl2_y, s_ctrl1_y, s_start_y};
    assign s_ready    = !q_full;

    cbt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_data (in_curve),
        .full      (q_full),
        .pop       (q_pop),
        .head_valid(head_valid),
        .head_data (head_data)
    );

    // The engine walks the head curve sample by sample and releases it with the last one.
    cbt_engine #(
        .SAMPLE_COUNT    (SAMPLE_COUNT),
        .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_data     (head_data),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample_x    (m_sample_x),
        .m_sample_y    (m_sample_y),
        .m_sample_index(m_sample_index),
        .m_last        (m_last)
    );

    // The engine only releases a curve that is actually present.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> head_valid)
        else $error("engine released a curve from an empty queue");

    // An accepted request is at the queue for the engine in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> head_valid)
        else $error("accepted request did not reach the queue");

    // Reset leaves no sample pending and the input side open.
    assert property (@(posedge aclk) !aresetn |=> (!m_valid && s_ready))
        else $error("state not cleared by reset");

endmodule
